FILE: rtl/gcci_pkg.sv
// Shared types and constants for the grid cell corner indexer.
// No dependencies; imported by every module of the block.
`default_nettype none

package gcci_pkg;

  // Fixed field widths
  localparam int IDX_W         = 24;  // element index and quotient word
  localparam int CNT_W         = 8;   // intervals per axis, cell coordinate
  localparam int VTX_W         = 24;  // vertex index
  localparam int CORNER_W      = 3;   // corner number port
  localparam int DIMENSION_DEF = 3;

  // One transaction as it travels down the cell chain
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] rem;   // running remainder, cell coordinate at axis end
    logic [IDX_W-1:0] word;  // dividend bits out, quotient bits in
    logic [VTX_W-1:0] vtx;   // base vertex index so far
    logic             oor;   // element beyond the grid
  } gcci_stage_t;

endpackage : gcci_pkg

`default_nettype wire

FILE: rtl/gcci_div_cell.sv
// One restoring-division cell: retires one quotient bit of the division by N.
// Depends on gcci_pkg.
`default_nettype none

module gcci_div_cell
  import gcci_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              en_i,
  input  wire [CNT_W-1:0]  n_i,
  input  gcci_stage_t      stage_i,
  output gcci_stage_t      stage_o
);

  logic              valid_q;
  gcci_stage_t       data_d, data_q;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  // Shift the next dividend bit into the remainder and try the subtraction
  always_comb begin
    trial  = {stage_i.rem, stage_i.word[IDX_W-1]};
    ge     = (trial >= {1'b0, n_i});
    diff   = trial - {1'b0, n_i};
    data_d = stage_i;
    data_d.rem  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    data_d.word = {stage_i.word[IDX_W-2:0], ge};
  end

  // Hold the control bit under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  // Advance the payload with the chain
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    stage_o       = data_q;
    stage_o.valid = valid_q;
  end

endmodule : gcci_div_cell

`default_nettype wire

FILE: rtl/gcci_axis_cell.sv
// Axis closing cell: folds the finished cell coordinate into the base vertex
// index and, on the last axis, flags elements beyond the grid. Uses gcci_pkg.
`default_nettype none

module gcci_axis_cell
  import gcci_pkg::*;
#(
  parameter bit LAST = 1'b0
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              en_i,
  input  wire [CNT_W-1:0]  n_i,
  input  wire [VTX_W-1:0]  weight_i,
  input  gcci_stage_t      stage_i,
  output gcci_stage_t      stage_o
);

  localparam int PROD_W = CNT_W + VTX_W;

  logic              valid_q;
  gcci_stage_t       data_d, data_q;
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(stage_i.rem) * PROD_W'(weight_i);

  // Add coordinate times axis weight; restart the remainder for the next axis
  always_comb begin
    data_d      = stage_i;
    data_d.vtx  = stage_i.vtx + prod[VTX_W-1:0];
    data_d.rem  = '0;
    data_d.oor  = LAST && ((n_i == '0) || (stage_i.word != '0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    stage_o       = data_q;
    stage_o.valid = valid_q;
  end

endmodule : gcci_axis_cell

`default_nettype wire

FILE: rtl/gcci_corner_emit.sv
// Corner emitter: walks the corners of one cell into an output register, one result
// per cycle while that register is free or being taken. Uses gcci_pkg.
`default_nettype none

module gcci_corner_emit
  import gcci_pkg::*;
#(
  parameter int DIMENSION = DIMENSION_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire  [VTX_W-1:0]    weight_i [DIMENSION],
  input  gcci_stage_t         stage_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [CORNER_W-1:0] corner_number_o,
  output logic [VTX_W-1:0]    vertex_index_o,
  output logic                last_corner_o,
  output logic                out_of_range_o
);

  localparam int NUM_CORNERS = 1 << DIMENSION;

  logic [VTX_W-1:0]     offset_d [NUM_CORNERS];
  logic [VTX_W-1:0]     offset_q [NUM_CORNERS];
  logic                 em_valid_q;
  logic [VTX_W-1:0]     em_vtx_q;
  logic                 em_oor_q;
  logic [DIMENSION-1:0] corner_q;
  logic                 slot_free;
  logic                 issue;
  logic                 is_last;
  logic                 load;

  // Corner offsets from the axis weights; follow the configuration
  always_comb begin
    for (int c = 0; c < NUM_CORNERS; c++) begin
      offset_d[c] = '0;
      for (int d = 0; d < DIMENSION; d++) begin
        if (((c >> d) & 1) == 1) begin
          offset_d[c] = offset_d[c] + weight_i[d];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NUM_CORNERS; c++) begin
      offset_q[c] <= offset_d[c];
    end
  end

  // Handshake between the held element and the output register
  assign slot_free = !out_valid_o || out_ready_i;
  assign issue     = em_valid_q && slot_free;
  assign is_last   = em_oor_q || (corner_q == DIMENSION'(NUM_CORNERS - 1));
  assign ready_o   = !em_valid_q || (issue && is_last);
  assign load      = ready_o && stage_i.valid;

  // Element control: load a new cell or step through its corners
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_valid_q <= 1'b0;
      corner_q   <= '0;
    end else if (load) begin
      em_valid_q <= 1'b1;
      corner_q   <= '0;
    end else if (issue) begin
      corner_q <= corner_q + 1'b1;
      if (is_last) begin
        em_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      em_vtx_q <= stage_i.vtx;
      em_oor_q <= stage_i.oor;
    end
  end

  // Output register: hold until the transaction is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (issue) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      corner_number_o <= em_oor_q ? '0 : CORNER_W'(corner_q);
      vertex_index_o  <= em_oor_q ? '0 : em_vtx_q + offset_q[corner_q];
      last_corner_o   <= is_last;
      out_of_range_o  <= em_oor_q;
    end
  end

endmodule : gcci_corner_emit

`default_nettype wire

FILE: rtl/grid_cell_corner_indexer.sv
// Grid cell corner indexer, top level.
// An accepted element passes the division and axis cells of each axis, then
// the emitter's element register and output register. The emitter issues
// one result per cycle while the output is taken, a single one when out of range.
// Reset: intervals per axis returns to 1, cell chain and output empty.
// Depends on gcci_pkg, gcci_div_cell, gcci_axis_cell, gcci_corner_emit.
`default_nettype none

module grid_cell_corner_indexer
  import gcci_pkg::*;
#(
  parameter int DIMENSION = DIMENSION_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [CNT_W-1:0]    cfg_wdata_i,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire  [IDX_W-1:0]    element_index_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [CORNER_W-1:0] corner_number_o,
  output logic [VTX_W-1:0]    vertex_index_o,
  output logic                last_corner_o,
  output logic                out_of_range_o
);

  localparam int AXIS_STAGES = IDX_W + 1;
  localparam int NUM_LINKS   = DIMENSION * AXIS_STAGES + 1;

  logic [CNT_W-1:0] intervals_q;
  logic [CNT_W:0]   n_plus_one;
  logic [VTX_W-1:0] weight [DIMENSION];
  gcci_stage_t      link [NUM_LINKS];
  logic             advance;
  logic             emit_ready;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intervals_q <= CNT_W'(1);
    end else if (cfg_we_i) begin
      intervals_q <= cfg_wdata_i;
    end
  end

  assign n_plus_one = {1'b0, intervals_q} + 1'b1;

  // Axis weights (N+1)^d; weight 0 is the constant 1, one register per higher power
  assign weight[0] = VTX_W'(1);
  for (genvar d = 1; d < DIMENSION; d++) begin : g_weight
    logic [VTX_W-1:0] weight_q;
    always_ff @(posedge clk_i) begin
      weight_q <= VTX_W'(weight[d-1] * VTX_W'(n_plus_one));
    end
    assign weight[d] = weight_q;
  end

  // Stall the whole chain while its last cell waits on the emitter
  assign advance    = !link[NUM_LINKS-1].valid || emit_ready;
  assign in_ready_o = advance;

  always_comb begin
    link[0]       = '0;
    link[0].valid = in_valid_i;
    link[0].word  = element_index_i;
  end

  // Per axis: one division cell per quotient bit, then the closing cell
  for (genvar d = 0; d < DIMENSION; d++) begin : g_axis
    for (genvar k = 0; k < IDX_W; k++) begin : g_bit
      gcci_div_cell u_div_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (advance),
        .n_i     (intervals_q),
        .stage_i (link[d*AXIS_STAGES + k]),
        .stage_o (link[d*AXIS_STAGES + k + 1])
      );
    end

    gcci_axis_cell #(
      .LAST (d == DIMENSION - 1)
    ) u_axis_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (advance),
      .n_i      (intervals_q),
      .weight_i (weight[d]),
      .stage_i  (link[d*AXIS_STAGES + IDX_W]),
      .stage_o  (link[(d+1)*AXIS_STAGES])
    );
  end

  gcci_corner_emit #(
    .DIMENSION (DIMENSION)
  ) u_corner_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .weight_i        (weight),
    .stage_i         (link[NUM_LINKS-1]),
    .ready_o         (emit_ready),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .corner_number_o (corner_number_o),
    .vertex_index_o  (vertex_index_o),
    .last_corner_o   (last_corner_o),
    .out_of_range_o  (out_of_range_o)
  );

endmodule : grid_cell_corner_indexer

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the grid cell corner indexer.
// Depends on gcci_pkg and grid_cell_corner_indexer; predicts corners in-bench.
`timescale 1ns / 100ps

module testbench;
  import gcci_pkg::*;

  localparam int DIM         = DIMENSION_DEF;
  localparam int CORNERS     = 1 << DIM;
  localparam int SETTLE      = DIM * 25 + 2 + 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PCT    = 15;

  typedef struct {
    logic [CORNER_W-1:0] corner;
    logic [VTX_W-1:0]    vertex;
    logic                last;
    logic                oor;
  } corner_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CNT_W-1:0]    cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [IDX_W-1:0]    element_index_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [CORNER_W-1:0] corner_number_o;
  logic [VTX_W-1:0]    vertex_index_o;
  logic                last_corner_o;
  logic                out_of_range_o;

  // Element indices waiting to be offered, and corners still owed by the block
  logic [IDX_W-1:0] element_pending[$];
  corner_t          corners_owed[$];

  int unsigned intervals = 1;   // shadow of the intervals-per-axis register
  bit          steady    = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned errors    = 0;
  int unsigned cycles    = 0;

  grid_cell_corner_indexer #(
    .DIMENSION(DIM)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .element_index_i(element_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .corner_number_o(corner_number_o),
    .vertex_index_o (vertex_index_o),
    .last_corner_o  (last_corner_o),
    .out_of_range_o (out_of_range_o)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned cell_count(input int unsigned n);
    int unsigned p;
    p = 1;
    for (int d = 0; d < DIM; d++) p = p * n;
    return p;
  endfunction

  // Split the element into axis coordinates and queue every corner it owns, or one out-of-range result
  function automatic void queue_cell_corners(input logic [IDX_W-1:0] idx);
    int unsigned n;
    int unsigned rest;
    int unsigned vtx;
    int unsigned weight;
    int unsigned coord[DIM];
    corner_t     c;
    n = intervals & 8'hFF;
    if (n == 0 || idx >= cell_count(n)) begin
      c.corner = '0;
      c.vertex = '0;
      c.last   = 1'b1;
      c.oor    = 1'b1;
      corners_owed.push_back(c);
      return;
    end
    rest = 32'(idx);
    for (int d = 0; d < DIM; d++) begin
      coord[d] = rest % n;
      rest     = rest / n;
    end
    for (int k = 0; k < CORNERS; k++) begin
      vtx    = 0;
      weight = 1;
      for (int d = 0; d < DIM; d++) begin
        vtx    = vtx + (coord[d] + ((k >> d) & 1)) * weight;
        weight = weight * (n + 1);
      end
      c.corner = k[CORNER_W-1:0];
      c.vertex = vtx[VTX_W-1:0];
      c.last   = (k == CORNERS - 1);
      c.oor    = 1'b0;
      corners_owed.push_back(c);
    end
  endfunction

  // Driver: advance to the next element once the current one is taken
  always @(posedge clk_i) begin : driver
    bit taken;
    if (rst_ni) begin
      taken = in_valid_i && in_ready_o;
      if (taken) queue_cell_corners(element_index_i);
      if (!in_valid_i || taken) begin
        if (element_pending.size() != 0 &&
            (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid_i      <= 1'b1;
          element_index_i <= element_pending.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each corner transaction against the oldest prediction
  always @(posedge clk_i) begin : monitor
    corner_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (corners_owed.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected corner: corner %0d vertex %0d last %0b oor %0b",
                     corner_number_o, vertex_index_o, last_corner_o, out_of_range_o);
        end else begin
          want = corners_owed.pop_front();
          if (corner_number_o !== want.corner || vertex_index_o !== want.vertex ||
              last_corner_o !== want.last || out_of_range_o !== want.oor) begin
            errors++;
            if (errors <= 10)
              $display("corner mismatch: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                       want.corner, want.vertex, want.last, want.oor,
                       corner_number_o, vertex_index_o, last_corner_o, out_of_range_o);
          end
        end
      end
      // Hold off once while a long burst is queued, so the block backs up
      if (!hold_done && element_pending.size() >= 30) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Write the register; only called while the block is empty
  task automatic set_intervals(input int unsigned n);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n[CNT_W-1:0];
    intervals    = n;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Wait for every element to be taken and every corner to arrive
  task automatic drain();
    while (element_pending.size() != 0 || in_valid_i || corners_owed.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Mostly well-formed indices, some anywhere in the field, some on the edge
  task automatic add_random(input int count);
    int unsigned total;
    int unsigned pick;
    total = cell_count(intervals);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (total == 0 || pick < 20)
        element_pending.push_back(IDX_W'($urandom_range(0, (1 << IDX_W) - 1)));
      else if (pick < 25)
        element_pending.push_back(IDX_W'(total - 1 + $urandom_range(0, 1)));
      else
        element_pending.push_back(IDX_W'($urandom_range(0, total - 1)));
    end
  endtask

  // Stimulus
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One interval, as after reset: a single cell, everything else out of range
    element_pending.push_back(24'd0);
    element_pending.push_back(24'd1);
    element_pending.push_back(24'h800000);
    element_pending.push_back(24'hFFFFFF);
    drain();

    // Widest grid: axis wraps, last cell, first index beyond the grid
    set_intervals(255);
    element_pending.push_back(24'd0);
    element_pending.push_back(24'd254);
    element_pending.push_back(24'd255);
    element_pending.push_back(24'd65024);
    element_pending.push_back(24'd65025);
    element_pending.push_back(24'h555555);
    element_pending.push_back(24'hAAAAAA);
    element_pending.push_back(24'd16581374);
    element_pending.push_back(24'd16581375);
    element_pending.push_back(24'hFFFFFF);
    drain();

    // Zero intervals: every element is out of range
    set_intervals(0);
    element_pending.push_back(24'd0);
    element_pending.push_back(24'd7);
    element_pending.push_back(24'hFFFFFF);
    drain();

    set_intervals(2);
    element_pending.push_back(24'd0);
    element_pending.push_back(24'd7);
    element_pending.push_back(24'd8);
    drain();

    // Random part; one phase runs with no idling at all
    steady = 1'b1;
    set_intervals(255);
    add_random(20);
    drain();
    steady = 1'b0;

    // Long burst, more than the cell chain can swallow, while the receiver holds off
    set_intervals(2);
    add_random(90);
    drain();

    set_intervals($urandom_range(3, 254));
    add_random(10);
    drain();

    set_intervals(17);
    add_random(10);
    drain();

    set_intervals(1);
    add_random(10);
    drain();

    set_intervals(0);
    add_random(5);
    drain();

    if (errors == 0 && corners_owed.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/gcci_pkg.sv
rtl/gcci_div_cell.sv
rtl/gcci_axis_cell.sv
rtl/gcci_corner_emit.sv
rtl/grid_cell_corner_indexer.sv
sim/testbench.sv
